// ===== design/box_intersection_over_union_defines.svh =====
// assertion macros shared by the checker files of the box iou block
// no dependencies; every macro is clocked on the rising edge and idle in reset
`ifndef BOX_INTERSECTION_OVER_UNION_DEFINES_SVH
`define BOX_INTERSECTION_OVER_UNION_DEFINES_SVH

// same-cycle implication
`define BXIOU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BXIOU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bxiou_pkg.sv =====
// constants, beat types and stage payloads of the box iou pipeline
// no dependencies
package bxiou_pkg;

    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int FRAC_BITS  = 16;
    localparam int AREA_BITS  = 2 * SIZE_BITS;
    localparam int UNION_BITS = AREA_BITS + 1;
    localparam int RATIO_BITS = FRAC_BITS + 1;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    // overlap stage, two area stages, one stage per quotient bit
    localparam int LATENCY    = 3 + DIV_STEPS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic        [SIZE_BITS-1:0]  first_width;
        logic        [SIZE_BITS-1:0]  first_height;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic        [SIZE_BITS-1:0]  second_width;
        logic        [SIZE_BITS-1:0]  second_height;
    } box_pair_t;

    typedef struct packed {
        logic [RATIO_BITS-1:0] overlap_ratio;
        logic                  union_empty;
    } iou_result_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] ow;
        logic [SIZE_BITS-1:0] oh;
        logic [SIZE_BITS-1:0] first_w;
        logic [SIZE_BITS-1:0] first_h;
        logic [SIZE_BITS-1:0] second_w;
        logic [SIZE_BITS-1:0] second_h;
    } span_beat_t;

    typedef struct packed {
        logic [AREA_BITS-1:0]  inter;
        logic [UNION_BITS-1:0] uni;
        logic                  empty;
    } div_job_t;

endpackage

// ===== design/bxiou_overlap.sv =====
// first pipeline stage: overlap length of the two boxes along each axis
// depends on bxiou_pkg
module bxiou_overlap
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  bxiou_pkg::box_pair_t   pair,
    output logic                   out_valid,
    output bxiou_pkg::span_beat_t  span
);

    // min of right edges minus max of left edges, zero when not positive
    function automatic logic [bxiou_pkg::SIZE_BITS-1:0] span_len
    (
        input logic signed [bxiou_pkg::COORD_BITS-1:0] lo1,
        input logic        [bxiou_pkg::SIZE_BITS-1:0]  len1,
        input logic signed [bxiou_pkg::COORD_BITS-1:0] lo2,
        input logic        [bxiou_pkg::SIZE_BITS-1:0]  len2
    );
        logic signed [bxiou_pkg::COORD_BITS:0]   l1;
        logic signed [bxiou_pkg::COORD_BITS:0]   l2;
        logic signed [bxiou_pkg::COORD_BITS:0]   r1;
        logic signed [bxiou_pkg::COORD_BITS:0]   r2;
        logic signed [bxiou_pkg::COORD_BITS:0]   rmin;
        logic signed [bxiou_pkg::COORD_BITS:0]   lmax;
        logic signed [bxiou_pkg::COORD_BITS+1:0] d;
        l1   = {lo1[bxiou_pkg::COORD_BITS-1], lo1};
        l2   = {lo2[bxiou_pkg::COORD_BITS-1], lo2};
        r1   = l1 + $signed({2'b00, len1});
        r2   = l2 + $signed({2'b00, len2});
        rmin = (r1 < r2) ? r1 : r2;
        lmax = (l1 > l2) ? l1 : l2;
        d    = {rmin[bxiou_pkg::COORD_BITS], rmin} - {lmax[bxiou_pkg::COORD_BITS], lmax};
        // d never exceeds the shorter length, so the low bits hold it
        if (!d[bxiou_pkg::COORD_BITS+1] && (d != '0))
        begin
            span_len = d[bxiou_pkg::SIZE_BITS-1:0];
        end
        else
        begin
            span_len = '0;
        end
    endfunction

    logic                  valid_reg;
    logic                  valid_next;
    bxiou_pkg::span_beat_t span_reg;
    bxiou_pkg::span_beat_t span_next;

    always_comb
    begin
        valid_next         = in_valid;
        span_next.ow       = span_len(pair.first_x, pair.first_width,
                                      pair.second_x, pair.second_width);
        span_next.oh       = span_len(pair.first_y, pair.first_height,
                                      pair.second_y, pair.second_height);
        span_next.first_w  = pair.first_width;
        span_next.first_h  = pair.first_height;
        span_next.second_w = pair.second_width;
        span_next.second_h = pair.second_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
    end

    assign out_valid = valid_reg;
    assign span      = span_reg;

endmodule

// ===== design/bxiou_area.sv =====
// second and third pipeline stages: the three areas, then union and empty flag
// depends on bxiou_pkg
module bxiou_area
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  bxiou_pkg::span_beat_t span,
    output logic                  out_valid,
    output bxiou_pkg::div_job_t   job
);

    logic                             prod_valid_reg;
    logic [bxiou_pkg::AREA_BITS-1:0]  inter_reg;
    logic [bxiou_pkg::AREA_BITS-1:0]  first_area_reg;
    logic [bxiou_pkg::AREA_BITS-1:0]  second_area_reg;
    logic [bxiou_pkg::AREA_BITS-1:0]  inter_next;
    logic [bxiou_pkg::AREA_BITS-1:0]  first_area_next;
    logic [bxiou_pkg::AREA_BITS-1:0]  second_area_next;
    logic                             job_valid_reg;
    bxiou_pkg::div_job_t              job_reg;
    bxiou_pkg::div_job_t              job_next;
    logic [bxiou_pkg::UNION_BITS-1:0] uni;

    // three narrow multipliers side by side
    always_comb
    begin
        inter_next       = {{bxiou_pkg::SIZE_BITS{1'b0}}, span.ow}
                         * {{bxiou_pkg::SIZE_BITS{1'b0}}, span.oh};
        first_area_next  = {{bxiou_pkg::SIZE_BITS{1'b0}}, span.first_w}
                         * {{bxiou_pkg::SIZE_BITS{1'b0}}, span.first_h};
        second_area_next = {{bxiou_pkg::SIZE_BITS{1'b0}}, span.second_w}
                         * {{bxiou_pkg::SIZE_BITS{1'b0}}, span.second_h};
    end

    // overlap never exceeds either area, so the union cannot go negative
    always_comb
    begin
        uni            = {1'b0, first_area_reg} + {1'b0, second_area_reg}
                       - {1'b0, inter_reg};
        job_next.inter = inter_reg;
        job_next.uni   = uni;
        job_next.empty = (uni == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            job_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            job_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        inter_reg       <= inter_next;
        first_area_reg  <= first_area_next;
        second_area_reg <= second_area_next;
        job_reg         <= job_next;
    end

    assign out_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

// ===== design/bxiou_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, msb (the 1.0 bit) first
// depends on bxiou_pkg
module bxiou_divider
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  bxiou_pkg::div_job_t    job,
    output logic                   out_valid,
    output bxiou_pkg::iou_result_t result
);

    logic                             valid_reg [bxiou_pkg::DIV_STEPS];
    logic                             empty_reg [bxiou_pkg::DIV_STEPS];
    logic [bxiou_pkg::UNION_BITS-1:0] den_reg   [bxiou_pkg::DIV_STEPS];
    logic [bxiou_pkg::UNION_BITS-1:0] rem_reg   [bxiou_pkg::DIV_STEPS];
    logic [bxiou_pkg::RATIO_BITS-1:0] quo_reg   [bxiou_pkg::DIV_STEPS];
    logic [bxiou_pkg::UNION_BITS-1:0] rem_next  [bxiou_pkg::DIV_STEPS];
    logic [bxiou_pkg::RATIO_BITS-1:0] quo_next  [bxiou_pkg::DIV_STEPS];

    for (genvar s = 0; s < bxiou_pkg::DIV_STEPS; s++)
    begin : g_step
        logic [bxiou_pkg::UNION_BITS:0]   trial;
        logic [bxiou_pkg::UNION_BITS:0]   diff;
        logic [bxiou_pkg::UNION_BITS-1:0] den;
        logic [bxiou_pkg::RATIO_BITS-1:0] quo_in;
        logic                             empty;
        logic                             valid_in;
        logic                             fits;

        if (s == 0)
        begin : g_first
            // first bit compares the overlap itself: set only for a full match
            always_comb
            begin
                trial    = {2'b00, job.inter};
                den      = job.uni;
                quo_in   = '0;
                empty    = job.empty;
                valid_in = in_valid;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                trial    = {rem_reg[s-1], 1'b0};
                den      = den_reg[s-1];
                quo_in   = quo_reg[s-1];
                empty    = empty_reg[s-1];
                valid_in = valid_reg[s-1];
            end
        end

        always_comb
        begin
            diff        = trial - {1'b0, den};
            fits        = !empty && (trial >= {1'b0, den});
            rem_next[s] = fits ? diff[bxiou_pkg::UNION_BITS-1:0]
                               : trial[bxiou_pkg::UNION_BITS-1:0];
            quo_next[s] = {quo_in[bxiou_pkg::RATIO_BITS-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            empty_reg[s] <= empty;
            den_reg[s]   <= den;
            rem_reg[s]   <= rem_next[s];
            quo_reg[s]   <= quo_next[s];
        end
    end

    // an empty union never sets a quotient bit, so the ratio is already zero
    assign out_valid            = valid_reg[bxiou_pkg::DIV_STEPS-1];
    assign result.overlap_ratio = quo_reg[bxiou_pkg::DIV_STEPS-1];
    assign result.union_empty   = empty_reg[bxiou_pkg::DIV_STEPS-1];

endmodule

// ===== design/box_intersection_over_union.sv =====
// box intersection over union: one box pair per clock
// pipeline: 1 overlap stage + 2 area stages + 17 divider stages, one quotient bit each
// throughput: one beat per cycle in both directions; busy stays low, nothing stalls
// the 17-stage quotient chain sets the latency; every stage runs every cycle
// reset (rst_n, async, active low) clears the valid bits; in-flight beats are dropped
// depends on bxiou_pkg, bxiou_overlap, bxiou_area, bxiou_divider
module box_intersection_over_union
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  bxiou_pkg::box_pair_t   boxes,
    output logic                   done,
    output bxiou_pkg::iou_result_t score
);

    // stage handoffs: a valid bit rides along with each payload
    logic                  span_valid;
    bxiou_pkg::span_beat_t span;
    logic                  job_valid;
    bxiou_pkg::div_job_t   job;

    // the pipeline never backs up, so every start beat is taken
    assign busy = 1'b0;

    // overlap width and height, clamped at zero for separated or touching boxes
    bxiou_overlap u_overlap
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .pair      (boxes),
        .out_valid (span_valid),
        .span      (span)
    );

    // overlap area and both box areas, then union and its empty flag
    bxiou_area u_area
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (span_valid),
        .span      (span),
        .out_valid (job_valid),
        .job       (job)
    );

    // overlap * 2^16 / union, truncated; the top bit stands for 1.0
    bxiou_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job_valid),
        .job       (job),
        .out_valid (done),
        .result    (score)
    );

endmodule

// ===== design/bxiou_checker.sv =====
// port-level checks on the box iou block, attached to the top level by bind
// depends on bxiou_pkg and box_intersection_over_union_defines.svh
`include "box_intersection_over_union_defines.svh"

module bxiou_checker
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input bxiou_pkg::iou_result_t score
);

    logic [bxiou_pkg::RATIO_BITS-1:0] full_ratio;
    assign full_ratio = {1'b1, {bxiou_pkg::FRAC_BITS{1'b0}}};

    `BXIOU_ASSERT_IMPLY(a_never_busy, clk, rst_n, 1'b1, !busy, "busy raised")
    `BXIOU_ASSERT_IMPLY(a_done_has_start, clk, rst_n, done, $past(start && !busy, bxiou_pkg::LATENCY), "result beat without a start beat")
    `BXIOU_ASSERT_IMPLY(a_ratio_bound, clk, rst_n, done, score.overlap_ratio <= full_ratio, "ratio above one")
    `BXIOU_ASSERT_IMPLY(a_empty_zero, clk, rst_n, done && score.union_empty, score.overlap_ratio == '0, "empty union with nonzero ratio")

endmodule

bind box_intersection_over_union bxiou_checker u_bxiou_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .score (score)
);
